// File: hdl/csvit_pkg.sv
// shared types, constants and helpers for the csv integer tokenizer
package csvit_pkg;

  localparam int POS_BITS    = 24;
  localparam int OUT_POS_W   = 24;
  localparam int NUM_W       = 31;
  localparam int BYTE_W      = 8;
  localparam int STATUS_W    = 3;
  localparam int IN_DATA_W   = 8;
  localparam int IN_USER_W   = 2;
  localparam int OUT_DATA_W  = 80;
  localparam int OUT_USER_W  = 3;

  localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

  typedef enum logic [STATUS_W-1:0] {
    ST_NUMBER   = 3'd0,
    ST_END      = 3'd1,
    ST_FAULT    = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_ILLEGAL  = 3'd5
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              end_of_input;
    logic              read_fault;
  } item_t;

  typedef struct packed {
    status_t              status;
    logic [NUM_W-1:0]     number;
    logic [OUT_POS_W-1:0] line_index;
    logic [OUT_POS_W-1:0] column_index;
  } result_t;

  // handshake between the step logic and the two register stages
  typedef struct packed {
    logic take;
    logic emit;
  } step_ctl_t;

  function automatic logic [OUT_POS_W-1:0] out_pos(input logic [POS_BITS-1:0] cnt);
    logic [31:0] wide;
    wide = 32'(cnt);
    return wide[OUT_POS_W-1:0];
  endfunction

endpackage

// File: hdl/csv_integer_tokenizer.sv
// top level of the csv integer tokenizer
// Takes one text byte per item and emits at most one result per item. The
// block accepts an item in every cycle while results are being taken; a
// result passes from the input register through the step logic - a multiply
// by ten done as shifts, an add and a compare - into the result register,
// where it is presented. Input stalls only when the result register is full
// and the downstream side is not ready. No clearing pass after reset.
module csv_integer_tokenizer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [csvit_pkg::IN_DATA_W-1:0]     s_tdata,   // text_byte
  input  logic [csvit_pkg::IN_USER_W-1:0]     s_tuser,   // end_of_input, read_fault
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [csvit_pkg::OUT_DATA_W-1:0]    m_tdata,   // number, line_index, column_index
  output logic [csvit_pkg::OUT_USER_W-1:0]    m_tuser    // status
);
  import csvit_pkg::*;

  item_t     s_item;
  item_t     in_item;
  logic      in_valid;
  logic      out_free;
  step_ctl_t ctl;
  result_t   res;
  result_t   out_res;

  assign s_item.text_byte    = s_tdata[BYTE_W-1:0];
  assign s_item.end_of_input = s_tuser[0];
  assign s_item.read_fault   = s_tuser[1];

  csvit_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_item   (s_item),
    .take     (ctl.take),
    .in_valid (in_valid),
    .in_item  (in_item)
  );

  csvit_core u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_item  (in_item),
    .out_free (out_free),
    .ctl      (ctl),
    .res      (res)
  );

  csvit_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .res      (res),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .out_res  (out_res)
  );

  assign m_tdata = {1'b0, out_res.column_index, out_res.line_index, out_res.number};
  assign m_tuser = out_res.status;

  a_number_only_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_NUMBER) |-> (m_tdata[NUM_W-1:0] == '0))
    else $error("nonzero number on an error or end result");

  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && !out_free)
    else $error("input stalled with room downstream");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    ctl.take && ctl.emit |=> m_tvalid)
    else $error("emitted result not presented");

endmodule

// File: hdl/csvit_in_stage.sv
// input register holding one accepted item until the step logic takes it
module csvit_in_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  csvit_pkg::item_t      s_item,
  input  logic                  take,
  output logic                  in_valid,
  output csvit_pkg::item_t      in_item
);
  import csvit_pkg::*;

  assign s_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= s_item;
    end
  end

endmodule

// File: hdl/csvit_core.sv
// field state, position counters and the per-byte step logic
module csvit_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  csvit_pkg::item_t      in_item,
  input  logic                  out_free,
  output csvit_pkg::step_ctl_t  ctl,
  output csvit_pkg::result_t    res
);
  import csvit_pkg::*;

  localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
  localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam int PROD_W = NUM_W + 4;

  logic [NUM_W-1:0]    accum, accum_next;
  logic                in_comment, in_comment_next;
  logic                have_digit, have_digit_next;
  logic [POS_BITS-1:0] row_count, row_count_next;
  logic [POS_BITS-1:0] col_count, col_count_next;

  logic [POS_BITS-1:0] row_inc, col_inc;
  logic [BYTE_W-1:0]   c;
  logic [BYTE_W-1:0]   digit_off;
  logic [PROD_W-1:0]   prod;
  logic                is_digit, ovf, emit;

  assign c         = in_item.text_byte;
  assign row_inc   = row_count + POS_BITS'(1);
  assign col_inc   = col_count + POS_BITS'(1);
  assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
  assign digit_off = c - CH_ZERO;
  // accum * 10 + d, as shifts and adds
  assign prod = (PROD_W'(accum) << 3) + (PROD_W'(accum) << 1) + PROD_W'(digit_off[3:0]);
  assign ovf  = prod > PROD_W'(NUM_MAX);

  assign ctl.take = in_valid && out_free;
  assign ctl.emit = emit;

  always_comb begin
    accum_next      = accum;
    in_comment_next = in_comment;
    have_digit_next = have_digit;
    row_count_next  = row_count;
    col_count_next  = col_count;
    emit             = 1'b0;
    res.status       = ST_NUMBER;
    res.number       = '0;
    res.line_index   = out_pos(row_count);
    res.column_index = out_pos(col_count);
    if (in_item.end_of_input) begin
      emit = 1'b1;
      if (have_digit) begin
        res.status = ST_NUMBER;
        res.number = accum;
      end else begin
        res.status = ST_END;
      end
    end else if (in_item.read_fault) begin
      emit       = 1'b1;
      res.status = ST_FAULT;
    end else if (c == CH_HASH) begin
      in_comment_next = 1'b1;
      col_count_next  = col_inc;
    end else if (c == CH_NL) begin
      in_comment_next = 1'b0;
      row_count_next  = row_inc;
      col_count_next  = '0;
      if (have_digit) begin
        col_count_next   = POS_BITS'(1);
        emit             = 1'b1;
        res.status       = ST_NUMBER;
        res.number       = accum;
        res.line_index   = out_pos(row_inc);
        res.column_index = out_pos(POS_BITS'(1));
      end
    end else if (!in_comment && c == CH_COMMA) begin
      emit = 1'b1;
      if (!have_digit) begin
        res.status = ST_EMPTY;
      end else begin
        col_count_next   = col_inc;
        res.status       = ST_NUMBER;
        res.number       = accum;
        res.column_index = out_pos(col_inc);
      end
    end else if (!in_comment && is_digit) begin
      have_digit_next = 1'b1;
      if (ovf) begin
        emit       = 1'b1;
        res.status = ST_OVERFLOW;
      end else begin
        accum_next     = prod[NUM_W-1:0];
        col_count_next = col_inc;
      end
    end else if (!in_comment && c != CH_SP && c != CH_TAB) begin
      emit       = 1'b1;
      res.status = ST_ILLEGAL;
    end else begin
      col_count_next = col_inc;
    end
    // field state clears after every result
    if (emit) begin
      accum_next      = '0;
      in_comment_next = 1'b0;
      have_digit_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum      <= '0;
      in_comment <= 1'b0;
      have_digit <= 1'b0;
      row_count  <= '0;
      col_count  <= '0;
    end else if (ctl.take) begin
      accum      <= accum_next;
      in_comment <= in_comment_next;
      have_digit <= have_digit_next;
      row_count  <= row_count_next;
      col_count  <= col_count_next;
    end
  end

endmodule

// File: hdl/csvit_out_stage.sv
// result register on the output side
module csvit_out_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  csvit_pkg::step_ctl_t  ctl,
  input  csvit_pkg::result_t    res,
  output logic                  out_free,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output csvit_pkg::result_t    out_res
);
  import csvit_pkg::*;

  logic load;

  assign out_free = !m_tvalid || m_tready;
  assign load     = ctl.take && ctl.emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

endmodule
